>>> sv/wshs_pkg.sv
// Shared constants, command codes and status bundle for the weighted sampler.
package wshs_pkg;

  localparam int NUM_BINS = 16;

  localparam logic [15:0] DPR_RESET = 16'd100;
  localparam logic [4:0]  BIU_RESET = 5'd16;
  localparam logic [4:0]  BINS_MAX  = 5'd16;
  localparam logic [6:0]  SHORT_DIV_STEPS = 7'd40;
  localparam logic [6:0]  LONG_DIV_STEPS  = 7'd72;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_DRAW   = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic REG_DRAWS_PER_ROUND = 1'b0;
  localparam logic REG_BINS_IN_USE     = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_ACCEPT, CMD_LOAD, CMD_TOT_ADD, CMD_MUL, CMD_SEARCH, CMD_COUNT,
    CMD_CLOSE_START, CMD_CLOSE, CMD_RPT_START, CMD_DIV_EXP, CMD_DIV_MEAN,
    CMD_VMUL_A, CMD_VMUL_B, CMD_DIV_VAR, CMD_DIV_STEP, CMD_SAVE_EXP,
    CMD_SAVE_MEAN, CMD_SAVE_VAR, CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic tot_last;   // index sits on the last bin in use
    logic all_last;   // index sits on the last physical bin
    logic tot_zero;
    logic found;
    logic close_due;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> sv/weighted_sampler_histogram_stats.sv
// Weighted sampler with per-round histogram statistics: top level.
// A draw sums the n bins in use, then searches them; a round close then walks all 16 physical bins.
// A report sums the bins in use, then per bin waits out the shared radix-2 divider
// (40 steps for expected count, 40 for mean, 72 for variance) and any output stall.
// One item at a time; a new item is taken while the last result still waits in the output register.
// Synchronous reset clears weights, statistics and counters and loads register defaults.
module weighted_sampler_histogram_stats
  import wshs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // bin_index, weight_value, uniform_fraction
  input  logic [1:0]   s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // report_bin, expected_count, mean_count,
                                  // count_variance, rounds_completed
  output logic         m_tlast    // last_bin
);

  cmd_t    cmd;
  status_t st;

  wshs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  wshs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> sv/wshs_ctrl.sv
// Sequencer for loads, draws, round closes and reports.
module wshs_ctrl
  import wshs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic [1:0] s_tuser,
  output logic       s_tready,
  input  status_t    st,
  output cmd_t       cmd
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_LOAD  = 19'h00002,
    S_DTOT  = 19'h00004,
    S_MUL   = 19'h00008,
    S_SRCH  = 19'h00010,
    S_COUNT = 19'h00020,
    S_CHECK = 19'h00040,
    S_CLOSE = 19'h00080,
    S_RTOT  = 19'h00100,
    S_RSTRT = 19'h00200,
    S_EXP   = 19'h00400,
    S_EXPR  = 19'h00800,
    S_MEAN  = 19'h01000,
    S_MEANR = 19'h02000,
    S_VMA   = 19'h04000,
    S_VMB   = 19'h08000,
    S_VAR   = 19'h10000,
    S_VARR  = 19'h20000,
    S_EMIT  = 19'h40000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = CMD_NONE;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd = CMD_ACCEPT;
          unique case (s_tuser)
            ACT_LOAD:   state_next = S_LOAD;
            ACT_DRAW:   state_next = S_DTOT;
            ACT_REPORT: state_next = S_RTOT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd = CMD_LOAD;
        state_next = S_IDLE;
      end
      S_DTOT: begin
        cmd = CMD_TOT_ADD;
        if (st.tot_last) state_next = S_MUL;
      end
      S_MUL: begin
        // drop the draw when the bins in use hold no weight
        if (st.tot_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd = CMD_MUL;
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd = CMD_SEARCH;
        if (st.found) state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd = CMD_COUNT;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.close_due) begin
          cmd = CMD_CLOSE_START;
          state_next = S_CLOSE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLOSE: begin
        cmd = CMD_CLOSE;
        if (st.all_last) state_next = S_IDLE;
      end
      S_RTOT: begin
        cmd = CMD_TOT_ADD;
        if (st.tot_last) state_next = S_RSTRT;
      end
      S_RSTRT: begin
        cmd = CMD_RPT_START;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd = CMD_DIV_EXP;
        state_next = S_EXPR;
      end
      S_EXPR: begin
        if (st.div_done) begin
          cmd = CMD_SAVE_EXP;
          state_next = S_MEAN;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_MEAN: begin
        cmd = CMD_DIV_MEAN;
        state_next = S_MEANR;
      end
      S_MEANR: begin
        if (st.div_done) begin
          cmd = CMD_SAVE_MEAN;
          state_next = S_VMA;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_VMA: begin
        cmd = CMD_VMUL_A;
        state_next = S_VMB;
      end
      S_VMB: begin
        cmd = CMD_VMUL_B;
        state_next = S_VAR;
      end
      S_VAR: begin
        cmd = CMD_DIV_VAR;
        state_next = S_VARR;
      end
      S_VARR: begin
        if (st.div_done) begin
          cmd = CMD_SAVE_VAR;
          state_next = S_EMIT;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd = CMD_EMIT;
          state_next = st.tot_last ? S_IDLE : S_EXP;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/wshs_dp.sv
// Datapath: bin tables, statistics, shared radix-2 divider and output register.
module wshs_dp
  import wshs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output status_t      st,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic [39:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,
  output logic         m_tlast
);

  logic [15:0] dpr;
  logic [4:0]  biu;
  logic [15:0] weights [NUM_BINS];
  logic [15:0] counts  [NUM_BINS];
  logic [31:0] sums    [NUM_BINS];
  logic [47:0] sqs     [NUM_BINS];
  logic [15:0] draws;
  logic [15:0] rounds;

  logic [3:0]  in_bin;
  logic [15:0] in_w;
  logic [15:0] in_u;
  logic [3:0]  idx;
  logic [19:0] total;
  logic [19:0] cum;
  logic [35:0] prod;
  logic [63:0] va, vb;
  logic [31:0] vd;
  logic [71:0] quo;
  logic [31:0] rem;
  logic [31:0] div_d;
  logic [6:0]  cnt;
  logic [23:0] exp_r, mean_r;
  logic [39:0] var_r;

  logic [4:0]  n_act, n_dec;
  logic [3:0]  n_m1;
  logic [15:0] lim;
  logic [19:0] cum_nx;
  logic [35:0] prod_nx;
  logic [31:0] exp_prod, sq;
  logic [32:0] sum_add;
  logic [48:0] sq_add;
  logic [63:0] va_nx, vb_nx;
  logic [31:0] vd_nx;
  logic [32:0] rem_sh, rem_sub;
  logic        ge;
  logic [23:0] q_sat24;
  logic [39:0] q_sat40;

  assign n_act   = (biu == 5'd0) ? 5'd1 : ((biu > BINS_MAX) ? BINS_MAX : biu);
  assign n_dec   = n_act - 5'd1;
  assign n_m1    = n_dec[3:0];
  assign lim     = (dpr == 16'd0) ? 16'd1 : dpr;
  assign cum_nx  = cum + {4'd0, weights[idx]};
  assign prod_nx = in_u * total;
  assign exp_prod = dpr * weights[idx];
  assign sq      = counts[idx] * counts[idx];
  assign sum_add = {1'b0, sums[idx]} + {17'd0, counts[idx]};
  assign sq_add  = {1'b0, sqs[idx]} + {17'd0, sq};
  assign va_nx   = sqs[idx] * rounds;
  assign vd_nx   = rounds * rounds;
  assign vb_nx   = sums[idx] * sums[idx];
  assign rem_sh  = {rem, quo[71]};
  assign ge      = rem_sh >= {1'b0, div_d};
  assign rem_sub = rem_sh - {1'b0, div_d};
  assign q_sat24 = (|quo[71:24]) ? 24'hFFFFFF : quo[23:0];
  assign q_sat40 = (|quo[71:40]) ? 40'hFFFFFFFFFF : quo[39:0];

  always_comb begin
    st.tot_last  = idx == n_m1;
    st.all_last  = idx == 4'(NUM_BINS - 1);
    st.tot_zero  = total == 20'd0;
    st.found     = prod < {cum_nx, 16'd0};
    st.close_due = draws >= lim;
    st.div_done  = cnt == 7'd0;
    st.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dpr <= DPR_RESET;
      biu <= BIU_RESET;
      for (int i = 0; i < NUM_BINS; i++) begin
        weights[i] <= '0;
        counts[i]  <= '0;
        sums[i]    <= '0;
        sqs[i]     <= '0;
      end
      draws    <= '0;
      rounds   <= '0;
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DRAWS_PER_ROUND: dpr <= cfg_data;
          REG_BINS_IN_USE:     biu <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && cmd != CMD_EMIT) m_tvalid <= 1'b0;
      unique case (cmd)
        CMD_ACCEPT: begin
          in_bin <= s_tdata[3:0];
          in_w   <= s_tdata[19:4];
          in_u   <= s_tdata[35:20];
          total  <= '0;
          idx    <= '0;
        end
        CMD_LOAD: begin
          weights[in_bin] <= in_w;
          for (int i = 0; i < NUM_BINS; i++) begin
            counts[i] <= '0;
            sums[i]   <= '0;
            sqs[i]    <= '0;
          end
          draws  <= '0;
          rounds <= '0;
        end
        CMD_TOT_ADD: begin
          total <= total + {4'd0, weights[idx]};
          idx   <= idx + 4'd1;
        end
        CMD_MUL: begin
          prod <= prod_nx;
          cum  <= '0;
          idx  <= '0;
        end
        CMD_SEARCH: begin
          // advance until the scaled fraction falls under the running sum
          if (!st.found) begin
            cum <= cum_nx;
            idx <= idx + 4'd1;
          end
        end
        CMD_COUNT: begin
          if (counts[idx] != 16'hFFFF) counts[idx] <= counts[idx] + 16'd1;
          draws <= draws + 16'd1;
        end
        CMD_CLOSE_START: idx <= '0;
        CMD_CLOSE: begin
          sums[idx]   <= sum_add[32] ? 32'hFFFFFFFF : sum_add[31:0];
          sqs[idx]    <= sq_add[48] ? 48'hFFFFFFFFFFFF : sq_add[47:0];
          counts[idx] <= '0;
          idx         <= idx + 4'd1;
          if (st.all_last) begin
            draws <= '0;
            if (rounds != 16'hFFFF) rounds <= rounds + 16'd1;
          end
        end
        CMD_RPT_START: idx <= '0;
        CMD_DIV_EXP: begin
          quo   <= {exp_prod, 8'd0, 32'd0};
          div_d <= {12'd0, total};
          rem   <= '0;
          cnt   <= SHORT_DIV_STEPS;
        end
        CMD_DIV_MEAN: begin
          quo   <= {sums[idx], 8'd0, 32'd0};
          div_d <= {16'd0, rounds};
          rem   <= '0;
          cnt   <= SHORT_DIV_STEPS;
        end
        CMD_VMUL_A: begin
          va <= va_nx;
          vd <= vd_nx;
        end
        CMD_VMUL_B: vb <= vb_nx;
        CMD_DIV_VAR: begin
          quo   <= {va - vb, 8'd0};
          div_d <= vd;
          rem   <= '0;
          cnt   <= LONG_DIV_STEPS;
        end
        CMD_DIV_STEP: begin
          rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
          quo <= {quo[70:0], ge};
          cnt <= cnt - 7'd1;
        end
        CMD_SAVE_EXP:  exp_r  <= st.tot_zero ? 24'd0 : q_sat24;
        CMD_SAVE_MEAN: mean_r <= (rounds == 16'd0) ? 24'd0 : q_sat24;
        CMD_SAVE_VAR:  var_r  <= (rounds == 16'd0 || va <= vb) ? 40'd0 : q_sat40;
        CMD_EMIT: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {4'd0, rounds, var_r, mean_r, exp_r, idx};
          m_tlast  <= st.tot_last;
          idx      <= idx + 4'd1;
        end
        default: ;
      endcase
    end
  end

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_LOAD |=> rounds == 16'd0 && draws == 16'd0)
    else $error("statistics not cleared by weight load");

  a_close_counts_round: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_CLOSE && st.all_last |=> rounds != 16'd0 && draws == 16'd0)
    else $error("round close did not advance round count");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_EMIT |=> m_tvalid)
    else $error("result transfer not presented after emit");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_EMIT |-> !m_tvalid || m_tready)
    else $error("output register overwritten");

endmodule
